// ===== hw/rtl/nts_pkg.sv =====
// Shared types and constants for the number token scanner.
`default_nettype none

package nts_pkg;

  // Character codes the classifier looks for
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Token kinds reported on token_kind
  localparam logic [1:0] KIND_INT    = 2'd0;
  localparam logic [1:0] KIND_INTDOT = 2'd1;
  localparam logic [1:0] KIND_FRAC   = 2'd2;

  localparam int TOKEN_W = 16;
  localparam int OUT_POS_W = 16;

  typedef enum logic [2:0] {
    CLS_SIGN,
    CLS_DIGIT,
    CLS_DOT,
    CLS_OTHER,
    CLS_NUL
  } char_class_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC
  } scan_state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MARK,
    ACT_INT,
    ACT_INTDOT,
    ACT_FRAC
  } scan_act_t;

endpackage

`default_nettype wire

// ===== hw/rtl/number_token_scanner.sv =====
// Top level of the number token scanner: input register, classifier, scanner.
`default_nettype none

// Takes one text byte per cycle unless the input stalls and reports numeric
// tokens (optional sign, digits, optional dot and more digits). The byte that
// ends a token sits in the input register and is processed into the result
// register once that register has room. Bytes that end no token give no
// result. The scan state, position and token start are updated together for
// each processed byte, so a new byte is taken every cycle unless stalled; the
// input stalls only while a byte is held and the result register is full and
// stalled. Positions count from reset or the last NUL and saturate at
// 2^POS_WIDTH - 1; the low 16 bits are reported.
module number_token_scanner
  import nts_pkg::*;
#(
  parameter int POS_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          char_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               token_kind,
  output logic [OUT_POS_W-1:0]     start_pos,
  output logic [OUT_POS_W-1:0]     end_pos,
  output logic [TOKEN_W-1:0]       token_number
);

  logic         hold_valid;
  logic [7:0]   hold_char;
  logic         take;
  char_class_t  char_class;

  // Stall only when the held byte cannot move on
  assign in_stall = hold_valid && !take;

  // Capture the incoming byte on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_char <= char_in;
    end
  end

  nts_classify u_classify (
    .char_in    (hold_char),
    .char_class (char_class)
  );

  nts_scan #(
    .POS_WIDTH (POS_WIDTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (hold_valid),
    .char_class   (char_class),
    .take         (take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .start_pos    (start_pos),
    .end_pos      (end_pos),
    .token_number (token_number)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/nts_classify.sv =====
// Byte classifier: maps one text byte to its character class.
`default_nettype none

module nts_classify
  import nts_pkg::*;
(
  input  wire logic [7:0]  char_in,
  output char_class_t      char_class
);

  // Pick the class, signs first
  always_comb begin
    priority if (char_in == CHAR_PLUS || char_in == CHAR_MINUS) begin
      char_class = CLS_SIGN;
    end else if (char_in >= CHAR_ZERO && char_in <= CHAR_NINE) begin
      char_class = CLS_DIGIT;
    end else if (char_in == CHAR_DOT) begin
      char_class = CLS_DOT;
    end else if (char_in == CHAR_NUL) begin
      char_class = CLS_NUL;
    end else begin
      char_class = CLS_OTHER;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nts_scan.sv =====
// Scanner state machine, position tracking and result register.
`default_nettype none

module nts_scan
  import nts_pkg::*;
#(
  parameter int POS_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  input  char_class_t                char_class,
  output logic                       take,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 token_kind,
  output logic [OUT_POS_W-1:0]       start_pos,
  output logic [OUT_POS_W-1:0]       end_pos,
  output logic [TOKEN_W-1:0]         token_number
);

  localparam logic [POS_WIDTH-1:0] POS_LIMIT = {POS_WIDTH{1'b1}};
  localparam logic [POS_WIDTH-1:0] POS_ONE   = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] POS_TWO   = POS_WIDTH'(2);

  scan_state_t            state;
  scan_state_t            state_next;
  scan_act_t              act;
  logic [POS_WIDTH-1:0]   position;
  logic [POS_WIDTH-1:0]   position_next;
  logic [POS_WIDTH-1:0]   token_start;
  logic [POS_WIDTH-1:0]   token_start_next;
  logic [TOKEN_W-1:0]     token_count;
  logic [POS_WIDTH-1:0]   base_start;
  logic [POS_WIDTH-1:0]   back;
  logic [POS_WIDTH-1:0]   end_raw;
  logic [POS_WIDTH-1:0]   end_sel;
  logic [31:0]            start_ext;
  logic [31:0]            end_ext;
  logic                   emit;
  logic                   in_start;
  logic [1:0]             kind;

  // Process the held byte once the result register has room
  assign take = item_valid && (!out_valid || !out_stall);

  // Next state from the transition table; NUL returns to start
  always_comb begin
    unique case (state)
      ST_INT: begin
        unique case (char_class)
          CLS_SIGN:  state_next = ST_SIGN;
          CLS_DIGIT: state_next = ST_INT;
          CLS_DOT:   state_next = ST_DOT;
          default:   state_next = ST_START;
        endcase
      end
      ST_DOT, ST_FRAC: begin
        unique case (char_class)
          CLS_SIGN:  state_next = ST_SIGN;
          CLS_DIGIT: state_next = ST_FRAC;
          default:   state_next = ST_START;
        endcase
      end
      default: begin
        unique case (char_class)
          CLS_SIGN:  state_next = ST_SIGN;
          CLS_DIGIT: state_next = ST_INT;
          default:   state_next = ST_START;
        endcase
      end
    endcase
  end

  // Action for this state and class
  always_comb begin
    unique case (state)
      ST_SIGN:  act = (char_class == CLS_DIGIT) ? ACT_NONE : ACT_MARK;
      ST_INT:   act = (char_class == CLS_DIGIT || char_class == CLS_DOT) ?
                      ACT_NONE : ACT_INT;
      ST_DOT:   act = (char_class == CLS_DIGIT) ? ACT_NONE : ACT_INTDOT;
      ST_FRAC:  act = (char_class == CLS_DIGIT) ? ACT_NONE : ACT_FRAC;
      default:  act = ACT_NONE;
    endcase
  end

  // Token bounds and register updates
  always_comb begin
    in_start = !(state == ST_SIGN || state == ST_INT ||
                 state == ST_DOT || state == ST_FRAC);
    base_start = in_start ? position : token_start;
    emit = (act == ACT_INT) || (act == ACT_INTDOT) || (act == ACT_FRAC);
    back = (act == ACT_INTDOT) ? POS_TWO : POS_ONE;
    end_raw = (position >= back) ? (position - back) : '0;
    end_sel = (end_raw < base_start) ? base_start : end_raw;
    unique case (act)
      ACT_INTDOT: kind = KIND_INTDOT;
      ACT_FRAC:   kind = KIND_FRAC;
      default:    kind = KIND_INT;
    endcase
    start_ext = 32'(base_start);
    end_ext   = 32'(end_sel);

    if (char_class == CLS_NUL) begin
      token_start_next = '0;
      position_next = '0;
    end else begin
      token_start_next = (emit || act == ACT_MARK) ? position : base_start;
      position_next = (position < POS_LIMIT) ? (position + POS_ONE) : position;
    end
  end

  // Advance scan state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_START;
      position    <= '0;
      token_start <= '0;
      token_count <= '0;
    end else if (take) begin
      state       <= (char_class == CLS_NUL) ? ST_START : state_next;
      position    <= position_next;
      token_start <= token_start_next;
      if (emit) begin
        token_count <= token_count + TOKEN_W'(1);
      end
    end
  end

  // Hold a result until its transfer, load a new one on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      token_kind   <= kind;
      start_pos    <= start_ext[OUT_POS_W-1:0];
      end_pos      <= end_ext[OUT_POS_W-1:0];
      token_number <= token_count;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nts_checker.sv =====
// Port checker for the number token scanner and its bind.
`default_nettype none

module nts_checker
  import nts_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic [1:0]          token_kind,
  input  wire logic [OUT_POS_W-1:0] start_pos,
  input  wire logic [OUT_POS_W-1:0] end_pos,
  input  wire logic [TOKEN_W-1:0]  token_number
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) &&
      $stable(start_pos) && $stable(end_pos) && $stable(token_number))
    else $error("stalled result changed");

  // Only the three defined kinds appear
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_kind == KIND_INT || token_kind == KIND_INTDOT ||
      token_kind == KIND_FRAC))
    else $error("undefined token kind");

  // Back-to-back results carry consecutive token numbers
  a_number: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall ##1 out_valid |->
      token_number == TOKEN_W'($past(token_number) + TOKEN_W'(1)))
    else $error("token number skipped");

  // Input stalls only while a byte is offered or a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_valid || (out_valid && out_stall))
    else $error("input stalled with free result register");

endmodule

bind number_token_scanner nts_checker u_nts_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the number token scanner.

module tb_top
  import nts_pkg::*;
;

  localparam int POS_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_BYTES = 1500;
  localparam int HOLD_CYCLES = 200;

  // One reported token
  typedef struct packed {
    logic [1:0]           kind;
    logic [OUT_POS_W-1:0] first_pos;
    logic [OUT_POS_W-1:0] last_pos;
    logic [TOKEN_W-1:0]   seq;
  } token_t;

  // Tracks the scan of the transferred bytes and matches reported tokens
  class token_tracker;
    scan_state_t        st = ST_START;
    logic [POS_W-1:0]   pos = '0;
    logic [POS_W-1:0]   tok_start = '0;
    logic [TOKEN_W-1:0] tok_count = '0;
    token_t             pending_tokens[$];
    int                 mismatches = 0;
    int                 bytes_taken = 0;
    int                 tokens_matched = 0;
    int                 kind_seen[3] = '{0, 0, 0};

    function char_class_t class_of(logic [7:0] c);
      if (c == CHAR_PLUS || c == CHAR_MINUS) return CLS_SIGN;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return CLS_DIGIT;
      if (c == CHAR_DOT) return CLS_DOT;
      if (c == CHAR_NUL) return CLS_NUL;
      return CLS_OTHER;
    endfunction

    // Queue the open token; its last byte is back positions behind, clamped to the start
    function void close_token(logic [1:0] kind, int back);
      logic [POS_W-1:0] stop;
      token_t           t;
      stop = (pos >= POS_W'(back)) ? pos - POS_W'(back) : '0;
      if (stop < tok_start) stop = tok_start;
      t.kind = kind;
      t.first_pos = tok_start[OUT_POS_W-1:0];
      t.last_pos = stop[OUT_POS_W-1:0];
      t.seq = tok_count;
      pending_tokens.push_back(t);
      tok_count++;
      tok_start = pos;
    endfunction

    function void take_byte(logic [7:0] c);
      char_class_t cls;
      cls = class_of(c);
      bytes_taken++;
      if (st == ST_START) tok_start = pos;

      // Close or re-mark the token depending on where the scan stands
      case (st)
        ST_SIGN: if (cls != CLS_DIGIT) tok_start = pos;
        ST_INT:  if (cls != CLS_DIGIT && cls != CLS_DOT) close_token(KIND_INT, 1);
        ST_DOT:  if (cls != CLS_DIGIT) close_token(KIND_INTDOT, 2);
        ST_FRAC: if (cls != CLS_DIGIT) close_token(KIND_FRAC, 1);
        default: ;
      endcase

      // Advance the scan; NUL restarts the line
      if (cls == CLS_NUL) begin
        st = ST_START;
        pos = '0;
        tok_start = '0;
      end else begin
        case (cls)
          CLS_SIGN:  st = ST_SIGN;
          CLS_DIGIT: st = (st == ST_DOT || st == ST_FRAC) ? ST_FRAC : ST_INT;
          CLS_DOT:   st = (st == ST_INT) ? ST_DOT : ST_START;
          default:   st = ST_START;
        endcase
        if (pos != POS_MAX) pos++;
      end
    endfunction

    function void match_token(logic [1:0] kind, logic [OUT_POS_W-1:0] first_pos,
                              logic [OUT_POS_W-1:0] last_pos, logic [TOKEN_W-1:0] seq);
      token_t want;
      if (pending_tokens.size() == 0) begin
        $error("token with none expected: kind %0d start %0d end %0d number %0d",
               kind, first_pos, last_pos, seq);
        mismatches++;
        return;
      end
      want = pending_tokens.pop_front();
      if (kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, kind);
        mismatches++;
      end
      if (first_pos !== want.first_pos) begin
        $error("start_pos: expected %0d, got %0d", want.first_pos, first_pos);
        mismatches++;
      end
      if (last_pos !== want.last_pos) begin
        $error("end_pos: expected %0d, got %0d", want.last_pos, last_pos);
        mismatches++;
      end
      if (seq !== want.seq) begin
        $error("token_number: expected %0d, got %0d", want.seq, seq);
        mismatches++;
      end
      tokens_matched++;
      if (want.kind <= KIND_FRAC) kind_seen[want.kind]++;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           char_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           token_kind;
  logic [OUT_POS_W-1:0] start_pos;
  logic [OUT_POS_W-1:0] end_pos;
  logic [TOKEN_W-1:0]   token_number;

  token_tracker tokens;
  int           send_idle_pct = 16;
  int           take_idle_pct = 16;
  bit           hold_req = 1'b0;
  int           hold_left = 0;
  int           bytes_sent = 0;
  longint       cycle_count = 0;

  // Signs, digits, dots, neighbors of the digit range, lone and repeated signs,
  // tokens closed by every kind of byte including NUL
  logic [7:0] directed_text[25] = '{
    CHAR_PLUS, CHAR_MINUS, "1", "2", CHAR_DOT, "5", CHAR_DOT,
    "9", CHAR_DOT, 8'h2F, "0", 8'h3A, CHAR_MINUS, 8'hFF,
    "3", CHAR_PLUS, "4", CHAR_NUL, "5", CHAR_DOT, CHAR_NUL,
    "8", CHAR_DOT, "6", CHAR_NUL
  };

  number_token_scanner #(.POS_WIDTH(POS_W)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_in      (char_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .start_pos    (start_pos),
    .end_pos      (end_pos),
    .token_number (token_number)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side at random, or hold it off for a long stretch on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < take_idle_pct);
    end
  end

  // Check finished tokens first, then track the byte taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tokens.match_token(token_kind, start_pos, end_pos,
                                                      token_number);
      if (in_valid && !in_stall) tokens.take_byte(char_in);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d tokens still expected", cycle_count,
             tokens.pending_tokens.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one byte, idling at random first, and wait for its transfer
  task automatic send_byte(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_digit();
    return 8'(CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_other();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (tokens.class_of(c) != CLS_OTHER);
    return c;
  endfunction

  // Send a random number-like run (signs, digits and a dot are each optional) and a random terminator
  task automatic send_number();
    int signs;
    signs = ($urandom_range(99) < 40) ? $urandom_range(1, 2) : 0;
    repeat (signs) send_byte($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
    repeat ($urandom_range(0, 4)) send_byte(pick_digit());
    if ($urandom_range(99) < 45) begin
      send_byte(CHAR_DOT);
      repeat ($urandom_range(0, 3)) send_byte(pick_digit());
    end
    case ($urandom_range(9))
      0:       send_byte(CHAR_NUL);
      1, 2:    send_byte($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
      3:       send_byte(CHAR_DOT);
      default: send_byte(pick_other());
    endcase
  endtask

  initial begin
    int  random_base;
    bit  hold_done;
    tokens = new();
    hold_done = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    char_in = 8'h00;
    out_stall = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_text[i]) send_byte(directed_text[i]);

    // Mostly number-like runs, some raw bytes; a long output hold and a stretch with no idles in the middle
    random_base = bytes_sent;
    while (bytes_sent - random_base < RANDOM_BYTES) begin
      if (!hold_done && bytes_sent - random_base >= 300) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (bytes_sent - random_base >= 700 && bytes_sent - random_base < 1100) begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end else begin
        send_idle_pct = 16;
        take_idle_pct = 16;
      end
      if ($urandom_range(99) < 15) send_byte(8'($urandom_range(0, 255)));
      else send_number();
    end
    send_byte(CHAR_NUL);

    @(negedge clk);
    in_valid <= 1'b0;
    while (tokens.pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Scanned %0d bytes under random and long output stalls, checked %0d tokens",
             tokens.bytes_taken, tokens.tokens_matched);
    $display("(%0d integer, %0d integer-dot, %0d fraction); %0d field mismatches",
             tokens.kind_seen[0], tokens.kind_seen[1], tokens.kind_seen[2],
             tokens.mismatches);
    if (tokens.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
